// ===== rtl/core/infix_to_postfix_converter_core_assert.svh =====
// Assertion macros used by the converter's back part.
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define I2P_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define I2P_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/i2p_pkg.sv =====
// Types, constants and helper functions of the infix to postfix converter.
package i2p_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int PTR_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_ADD   = 8'h2B;
	localparam logic [7:0] CH_SUB   = 8'h2D;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_POW   = 8'h5E;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_NUL   = 8'h00;

	typedef enum logic [2:0] {
		OC_OPEN = 3'd0,
		OC_ADD  = 3'd1,
		OC_SUB  = 3'd2,
		OC_MUL  = 3'd3,
		OC_DIV  = 3'd4,
		OC_POW  = 3'd5
	} op_code_t;

	typedef enum logic [2:0] {
		ST_OK              = 3'd0,
		ST_OVERFLOW        = 3'd1,
		ST_UNMATCHED_CLOSE = 3'd2,
		ST_UNMATCHED_OPEN  = 3'd3,
		ST_INVALID         = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		K_LETTER,
		K_OPEN,
		K_CLOSE,
		K_OP,
		K_INVALID
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] ch;
		op_code_t   code;
		logic       last;
	} cmd_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_CLOSE,
		BS_OP,
		BS_FLUSH,
		BS_FIN
	} back_state_t;

	function automatic logic [7:0] code_char(input op_code_t code);
		logic [7:0] c;
		unique case (code)
			OC_OPEN: c = CH_OPEN;
			OC_ADD:  c = CH_ADD;
			OC_SUB:  c = CH_SUB;
			OC_MUL:  c = CH_MUL;
			OC_DIV:  c = CH_DIV;
			OC_POW:  c = CH_POW;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] code_prec(input op_code_t code);
		logic [1:0] p;
		unique case (code)
			OC_ADD, OC_SUB: p = 2'd1;
			OC_MUL, OC_DIV: p = 2'd2;
			OC_POW:         p = 2'd3;
			default:        p = 2'd0;
		endcase
		return p;
	endfunction

endpackage

// ===== rtl/core/i2p_front.sv =====
// Input stage: accepts characters and classifies them into commands.
module i2p_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           src_valid,
	output logic           src_stall,
	input  logic [7:0]     ch,
	input  logic           is_last,
	output logic           cmd_valid,
	input  logic           cmd_full,
	output i2p_pkg::cmd_t  cmd
);

	logic          v_s1;
	i2p_pkg::cmd_t cmd_s1;
	i2p_pkg::cmd_t cls;
	logic          take;
	logic          move;

	always_comb begin
		cls.ch = ch;
		cls.last = is_last;
		cls.code = i2p_pkg::OC_OPEN;
		unique case (ch) inside
			[i2p_pkg::CH_UP_A:i2p_pkg::CH_UP_Z], [i2p_pkg::CH_LO_A:i2p_pkg::CH_LO_Z]: begin
				cls.kind = i2p_pkg::K_LETTER;
			end
			i2p_pkg::CH_OPEN: begin
				cls.kind = i2p_pkg::K_OPEN;
			end
			i2p_pkg::CH_CLOSE: begin
				cls.kind = i2p_pkg::K_CLOSE;
			end
			i2p_pkg::CH_ADD: begin
				cls.kind = i2p_pkg::K_OP;
				cls.code = i2p_pkg::OC_ADD;
			end
			i2p_pkg::CH_SUB: begin
				cls.kind = i2p_pkg::K_OP;
				cls.code = i2p_pkg::OC_SUB;
			end
			i2p_pkg::CH_MUL: begin
				cls.kind = i2p_pkg::K_OP;
				cls.code = i2p_pkg::OC_MUL;
			end
			i2p_pkg::CH_DIV: begin
				cls.kind = i2p_pkg::K_OP;
				cls.code = i2p_pkg::OC_DIV;
			end
			i2p_pkg::CH_POW: begin
				cls.kind = i2p_pkg::K_OP;
				cls.code = i2p_pkg::OC_POW;
			end
			default: begin
				cls.kind = i2p_pkg::K_INVALID;
			end
		endcase
	end

	assign src_stall = v_s1 && cmd_full;
	assign take = src_valid && !src_stall;
	assign move = v_s1 && !cmd_full;
	assign cmd_valid = v_s1;
	assign cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (move) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cls;
		end
	end

endmodule

// ===== rtl/core/i2p_queue.sv =====
// Short command queue between the front and back parts.
module i2p_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           full,
	input  i2p_pkg::cmd_t  wr_data,
	output logic           rd_valid,
	input  logic           rd_en,
	output i2p_pkg::cmd_t  rd_data
);

	i2p_pkg::cmd_t                 entry_q [i2p_pkg::QUEUE_DEPTH];
	logic [i2p_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [i2p_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [i2p_pkg::QCNT_W-1:0]    cnt_q;
	logic                          wr;
	logic                          rd;

	assign full = cnt_q == i2p_pkg::QCNT_W'(i2p_pkg::QUEUE_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign wr = wr_valid && !full;
	assign rd = rd_en && rd_valid;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == i2p_pkg::QPTR_W'(i2p_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == i2p_pkg::QPTR_W'(i2p_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/core/i2p_back.sv =====
// Execution part: operator stack, pending result and output register.
`include "infix_to_postfix_converter_core_assert.svh"

module i2p_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  i2p_pkg::cmd_t  cmd,
	output logic           cmd_pop,
	output logic           dst_valid,
	input  logic           dst_stall,
	output logic [7:0]     symbol,
	output logic           is_end,
	output logic           run_last,
	output logic [2:0]     status
);

	i2p_pkg::back_state_t      state_q, state_d;
	i2p_pkg::cmd_t             cmd_q, cmd_d;
	logic [i2p_pkg::CNT_W-1:0] cnt_q, cnt_d;
	i2p_pkg::status_t          err_q, err_d;
	i2p_pkg::op_code_t         stack_mem [i2p_pkg::STACK_DEPTH];
	i2p_pkg::op_code_t         top_q;
	logic [i2p_pkg::PTR_W-1:0] rd_idx;

	logic                      push_en;
	i2p_pkg::op_code_t         push_code;
	logic                      emit_en;
	logic [7:0]                emit_sym;
	logic                      emit_end;
	logic                      fin_flush;
	logic                      out_free;
	logic                      blk;
	logic                      full;
	logic                      pops;
	logic                      out_load;

	logic                      pend_v_q;
	logic [7:0]                pend_sym_q;
	logic                      pend_end_q;
	i2p_pkg::status_t          pend_st_q;

	logic                      out_v_q;
	logic [7:0]                out_sym_q;
	logic                      out_end_q;
	logic                      out_last_q;
	i2p_pkg::status_t          out_st_q;

	assign out_free = !out_v_q || !dst_stall;
	assign blk = pend_v_q && !out_free;
	assign full = cnt_q == i2p_pkg::DEPTH_CNT;
	assign pops = (i2p_pkg::code_prec(top_q) > i2p_pkg::code_prec(cmd_q.code)) ||
		((i2p_pkg::code_prec(top_q) == i2p_pkg::code_prec(cmd_q.code)) &&
		(cmd_q.code != i2p_pkg::OC_POW));

	always_comb begin
		state_d = state_q;
		cmd_d = cmd_q;
		cnt_d = cnt_q;
		err_d = err_q;
		cmd_pop = 1'b0;
		push_en = 1'b0;
		push_code = i2p_pkg::OC_OPEN;
		emit_en = 1'b0;
		emit_sym = i2p_pkg::CH_NUL;
		emit_end = 1'b0;
		fin_flush = 1'b0;
		unique case (state_q)
			i2p_pkg::BS_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					cmd_d = cmd;
					unique case (cmd.kind)
						i2p_pkg::K_LETTER: begin
							emit_en = 1'b1;
							emit_sym = cmd.ch;
							state_d = cmd.last ? i2p_pkg::BS_FLUSH : i2p_pkg::BS_FIN;
						end
						i2p_pkg::K_OPEN: begin
							if (full) begin
								if (err_q == i2p_pkg::ST_OK) err_d = i2p_pkg::ST_OVERFLOW;
							end else begin
								push_en = 1'b1;
								cnt_d = cnt_q + 1'b1;
							end
							state_d = cmd.last ? i2p_pkg::BS_FLUSH : i2p_pkg::BS_IDLE;
						end
						i2p_pkg::K_CLOSE: begin
							state_d = i2p_pkg::BS_CLOSE;
						end
						i2p_pkg::K_OP: begin
							state_d = i2p_pkg::BS_OP;
						end
						default: begin
							if (err_q == i2p_pkg::ST_OK) err_d = i2p_pkg::ST_INVALID;
							state_d = cmd.last ? i2p_pkg::BS_FLUSH : i2p_pkg::BS_IDLE;
						end
					endcase
				end
			end
			i2p_pkg::BS_CLOSE: begin
				if (cnt_q == '0) begin
					if (err_q == i2p_pkg::ST_OK) err_d = i2p_pkg::ST_UNMATCHED_CLOSE;
					state_d = cmd_q.last ? i2p_pkg::BS_FLUSH : i2p_pkg::BS_FIN;
				end else if (top_q == i2p_pkg::OC_OPEN) begin
					cnt_d = cnt_q - 1'b1;
					state_d = cmd_q.last ? i2p_pkg::BS_FLUSH : i2p_pkg::BS_FIN;
				end else if (!blk) begin
					emit_en = 1'b1;
					emit_sym = i2p_pkg::code_char(top_q);
					cnt_d = cnt_q - 1'b1;
				end
			end
			i2p_pkg::BS_OP: begin
				if (cnt_q != '0 && top_q != i2p_pkg::OC_OPEN && pops) begin
					if (!blk) begin
						emit_en = 1'b1;
						emit_sym = i2p_pkg::code_char(top_q);
						cnt_d = cnt_q - 1'b1;
					end
				end else begin
					if (full) begin
						if (err_q == i2p_pkg::ST_OK) err_d = i2p_pkg::ST_OVERFLOW;
					end else begin
						push_en = 1'b1;
						push_code = cmd_q.code;
						cnt_d = cnt_q + 1'b1;
					end
					state_d = cmd_q.last ? i2p_pkg::BS_FLUSH : i2p_pkg::BS_FIN;
				end
			end
			i2p_pkg::BS_FLUSH: begin
				if (cnt_q != '0) begin
					if (top_q == i2p_pkg::OC_OPEN) begin
						if (err_q == i2p_pkg::ST_OK) err_d = i2p_pkg::ST_UNMATCHED_OPEN;
						cnt_d = cnt_q - 1'b1;
					end else if (!blk) begin
						emit_en = 1'b1;
						emit_sym = i2p_pkg::code_char(top_q);
						cnt_d = cnt_q - 1'b1;
					end
				end else if (!blk) begin
					emit_en = 1'b1;
					emit_end = 1'b1;
					err_d = i2p_pkg::ST_OK;
					state_d = i2p_pkg::BS_FIN;
				end
			end
			i2p_pkg::BS_FIN: begin
				if (!pend_v_q) begin
					state_d = i2p_pkg::BS_IDLE;
				end else if (out_free) begin
					fin_flush = 1'b1;
					state_d = i2p_pkg::BS_IDLE;
				end
			end
			default: begin
				state_d = i2p_pkg::BS_IDLE;
			end
		endcase
	end

	assign out_load = (emit_en && pend_v_q) || fin_flush;
	assign rd_idx = i2p_pkg::PTR_W'(cnt_d - i2p_pkg::CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2p_pkg::BS_IDLE;
			cnt_q <= '0;
			err_q <= i2p_pkg::ST_OK;
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			err_q <= err_d;
			if (emit_en) begin
				pend_v_q <= 1'b1;
			end else if (fin_flush) begin
				pend_v_q <= 1'b0;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (!dst_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		if (push_en) begin
			stack_mem[i2p_pkg::PTR_W'(cnt_q)] <= push_code;
			top_q <= push_code;
		end else if (cnt_d != '0) begin
			top_q <= stack_mem[rd_idx];
		end
		if (emit_en) begin
			pend_sym_q <= emit_sym;
			pend_end_q <= emit_end;
			pend_st_q <= emit_end ? err_q : i2p_pkg::ST_OK;
		end
		if (out_load) begin
			out_sym_q <= pend_sym_q;
			out_end_q <= pend_end_q;
			out_st_q <= pend_st_q;
			out_last_q <= fin_flush;
		end
	end

	assign dst_valid = out_v_q;
	assign symbol = out_sym_q;
	assign is_end = out_end_q;
	assign run_last = out_last_q;
	assign status = out_st_q;

	`I2P_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= i2p_pkg::DEPTH_CNT, "stack count beyond depth")
	`I2P_ASSERT_IMP(a_idle_no_pend, state_q == i2p_pkg::BS_IDLE, !pend_v_q, "result left pending")
	`I2P_ASSERT_IMP(a_end_record, dst_valid && is_end, symbol == 8'h00 && run_last, "bad end record")
	`I2P_ASSERT_NXT(a_end_clears, emit_en && emit_end, cnt_q == '0 && err_q == i2p_pkg::ST_OK, "state kept after end")

endmodule

// ===== rtl/core/infix_to_postfix_converter_core.sv =====
// Infix to postfix converter: top level joining the front, queue and back parts.
// Input channel: one character per transfer on ch with is_last marking the final
// character of an expression; src_valid/src_stall handshake.
// Output channel: postfix symbols on symbol, then one record with is_end set and
// the expression status; run_last marks the final result caused by an input item.
// A character passes the input register and the two-entry command queue before the
// back part takes it; each result waits in a pending register until the next one
// is known. In the back part a letter, a '(' or an invalid character is handled in
// the idle state; a ')' or an operator moves to its own state, which pops stacked
// operators one at a time, and is_last leads to the flush state, which empties the
// stack and then writes the end record; every item that yields results, and every
// ')' or operator, then passes the closing state. The stack's single read port sets
// one pop per cycle, and a pop that emits a result waits while the output is blocked.
// Reset empties the stack, the queue and the output register and clears the status;
// stack entries are not cleared and are only read below the fill count.
// While the receiver stalls, the output register holds its result; the back part stops
// at its next result, the queue fills, and src_stall rises.
module infix_to_postfix_converter_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic [7:0] ch,
	input  logic       is_last,
	output logic       dst_valid,
	input  logic       dst_stall,
	output logic [7:0] symbol,
	output logic       is_end,
	output logic       run_last,
	output logic [2:0] status
);

	logic          f_valid;
	logic          q_full;
	i2p_pkg::cmd_t f_cmd;
	logic          q_valid;
	logic          q_pop;
	i2p_pkg::cmd_t q_cmd;

	i2p_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.ch        (ch),
		.is_last   (is_last),
		.cmd_valid (f_valid),
		.cmd_full  (q_full),
		.cmd       (f_cmd)
	);

	i2p_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.full     (q_full),
		.wr_data  (f_cmd),
		.rd_valid (q_valid),
		.rd_en    (q_pop),
		.rd_data  (q_cmd)
	);

	i2p_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_pop   (q_pop),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.symbol    (symbol),
		.is_end    (is_end),
		.run_last  (run_last),
		.status    (status)
	);

endmodule
